// ===== rtl/cawf_pkg.sv =====
`timescale 1ns / 1ps

package cawf_pkg;

    // Operation codes carried in the action field.
    localparam logic [4:0] ACT_ADD  = 5'd0;
    localparam logic [4:0] ACT_ADC  = 5'd1;
    localparam logic [4:0] ACT_SUB  = 5'd2;
    localparam logic [4:0] ACT_AND  = 5'd3;
    localparam logic [4:0] ACT_OR   = 5'd4;
    localparam logic [4:0] ACT_XOR  = 5'd5;
    localparam logic [4:0] ACT_CP   = 5'd6;
    localparam logic [4:0] ACT_INC  = 5'd7;
    localparam logic [4:0] ACT_DEC  = 5'd8;
    localparam logic [4:0] ACT_SWAP = 5'd9;
    localparam logic [4:0] ACT_DAA  = 5'd10;
    localparam logic [4:0] ACT_CPL  = 5'd11;
    localparam logic [4:0] ACT_CCF  = 5'd12;
    localparam logic [4:0] ACT_SCF  = 5'd13;
    localparam logic [4:0] ACT_RLCA = 5'd14;
    localparam logic [4:0] ACT_RLA  = 5'd15;
    localparam logic [4:0] ACT_RRCA = 5'd16;
    localparam logic [4:0] ACT_RRA  = 5'd17;
    localparam logic [4:0] ACT_RLC  = 5'd18;
    localparam logic [4:0] ACT_RL   = 5'd19;
    localparam logic [4:0] ACT_RRC  = 5'd20;
    localparam logic [4:0] ACT_RR   = 5'd21;
    localparam logic [4:0] ACT_SLA  = 5'd22;
    localparam logic [4:0] ACT_SRA  = 5'd23;
    localparam logic [4:0] ACT_SRL  = 5'd24;
    localparam logic [4:0] ACT_BIT  = 5'd25;
    localparam logic [4:0] ACT_SET  = 5'd26;
    localparam logic [4:0] ACT_RES  = 5'd27;

    // Decimal adjust constants.
    localparam logic [7:0] DAA_LOW_ADJ  = 8'h06;
    localparam logic [7:0] DAA_HIGH_ADJ = 8'h60;
    localparam logic [7:0] DAA_HIGH_MAX = 8'h99;
    localparam logic [3:0] DAA_LOW_MAX  = 4'h9;
    localparam logic [3:0] NIBBLE_ALL   = 4'hF;

    // Flag register, Z in the top bit down to C in the bottom bit.
    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } flags_t;

    typedef struct packed {
        logic [4:0] action;
        logic [7:0] operand;
        logic [2:0] bit_index;
    } req_t;

    typedef struct packed {
        logic [7:0] register_result;
        logic [7:0] accumulator_out;
        logic       flag_zero;
        logic       flag_subtract;
        logic       flag_half;
        logic       flag_carry;
    } rsp_t;

endpackage

// ===== rtl/cawf_alu.sv =====
`timescale 1ns / 1ps

module cawf_alu
    import cawf_pkg::*;
(
    input  req_t        req,
    input  logic [7:0]  acc,
    input  flags_t      flags,
    output logic [7:0]  reg_out,
    output logic [7:0]  acc_out,
    output flags_t      flags_out
);

    logic [7:0] v;
    logic [7:0] a;
    logic       cin;
    logic       add_cin;
    logic [8:0] sum9;
    logic [4:0] half5;
    logic [8:0] diff9;
    logic       half_borrow;
    logic [7:0] and_r;
    logic [7:0] or_r;
    logic [7:0] xor_r;
    logic [7:0] inc_r;
    logic [7:0] dec_r;
    logic [7:0] daa_hi;
    logic [7:0] daa_r;
    logic       daa_c;
    logic [7:0] bit_mask;

    assign v   = req.operand;
    assign a   = acc;
    assign cin = flags.c;

    // Adder and subtractor shared by add, adc, sub and cp.
    assign add_cin     = (req.action == ACT_ADC) ? cin : 1'b0;
    assign sum9        = {1'b0, a} + {1'b0, v} + {8'd0, add_cin};
    assign half5       = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, add_cin};
    assign diff9       = {1'b0, a} - {1'b0, v};
    assign half_borrow = (a[3:0] < v[3:0]);

    assign and_r = a & v;
    assign or_r  = a | v;
    assign xor_r = a ^ v;
    assign inc_r = v + 8'd1;
    assign dec_r = v - 8'd1;

    // Decimal adjust: after an add the correction depends on the digits too,
    // after a subtract only on the saved carry and half carry.
    always_comb
    begin
        daa_c  = cin;
        daa_hi = a;
        daa_r  = a;
        if (!flags.n)
        begin
            if (cin || (a > DAA_HIGH_MAX))
            begin
                daa_hi = a + DAA_HIGH_ADJ;
                daa_c  = 1'b1;
            end
            if (flags.h || (daa_hi[3:0] > DAA_LOW_MAX))
                daa_r = daa_hi + DAA_LOW_ADJ;
            else
                daa_r = daa_hi;
        end
        else
        begin
            if (cin)
                daa_hi = a - DAA_HIGH_ADJ;
            if (flags.h)
                daa_r = daa_hi - DAA_LOW_ADJ;
            else
                daa_r = daa_hi;
        end
    end

    assign bit_mask = 8'd1 << req.bit_index;

    // Operation select. Unused codes leave the state alone.
    always_comb
    begin
        reg_out   = 8'd0;
        acc_out   = a;
        flags_out = flags;
        unique case (req.action)
            ACT_ADD, ACT_ADC:
            begin
                acc_out   = sum9[7:0];
                flags_out = '{z: (sum9[7:0] == 8'd0), n: 1'b0, h: half5[4], c: sum9[8]};
            end
            ACT_SUB, ACT_CP:
            begin
                if (req.action == ACT_SUB)
                    acc_out = diff9[7:0];
                flags_out = '{z: (diff9[7:0] == 8'd0), n: 1'b1, h: half_borrow, c: diff9[8]};
            end
            ACT_AND:
            begin
                acc_out   = and_r;
                flags_out = '{z: (and_r == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
            end
            ACT_OR:
            begin
                acc_out   = or_r;
                flags_out = '{z: (or_r == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            ACT_XOR:
            begin
                acc_out   = xor_r;
                flags_out = '{z: (xor_r == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            ACT_INC:
            begin
                reg_out   = inc_r;
                flags_out = '{z: (inc_r == 8'd0), n: 1'b0, h: (v[3:0] == NIBBLE_ALL), c: cin};
            end
            ACT_DEC:
            begin
                reg_out   = dec_r;
                flags_out = '{z: (dec_r == 8'd0), n: 1'b1, h: (v[3:0] == 4'd0), c: cin};
            end
            ACT_SWAP:
            begin
                reg_out   = {v[3:0], v[7:4]};
                flags_out = '{z: (v == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            ACT_DAA:
            begin
                acc_out   = daa_r;
                flags_out = '{z: (daa_r == 8'd0), n: flags.n, h: 1'b0, c: daa_c};
            end
            ACT_CPL:
            begin
                acc_out   = ~a;
                flags_out = '{z: flags.z, n: 1'b1, h: 1'b1, c: cin};
            end
            ACT_CCF:
                flags_out = '{z: flags.z, n: 1'b0, h: 1'b0, c: ~cin};
            ACT_SCF:
                flags_out = '{z: flags.z, n: 1'b0, h: 1'b0, c: 1'b1};
            ACT_RLCA:
            begin
                acc_out   = {a[6:0], a[7]};
                flags_out = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
            end
            ACT_RLA:
            begin
                acc_out   = {a[6:0], cin};
                flags_out = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
            end
            ACT_RRCA:
            begin
                acc_out   = {a[0], a[7:1]};
                flags_out = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
            end
            ACT_RRA:
            begin
                acc_out   = {cin, a[7:1]};
                flags_out = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
            end
            ACT_RLC:
            begin
                reg_out   = {v[6:0], v[7]};
                flags_out = '{z: (v == 8'd0), n: 1'b0, h: 1'b0, c: v[7]};
            end
            ACT_RL:
            begin
                reg_out   = {v[6:0], cin};
                flags_out = '{z: ({v[6:0], cin} == 8'd0), n: 1'b0, h: 1'b0, c: v[7]};
            end
            ACT_RRC:
            begin
                reg_out   = {v[0], v[7:1]};
                flags_out = '{z: (v == 8'd0), n: 1'b0, h: 1'b0, c: v[0]};
            end
            ACT_RR:
            begin
                reg_out   = {cin, v[7:1]};
                flags_out = '{z: ({cin, v[7:1]} == 8'd0), n: 1'b0, h: 1'b0, c: v[0]};
            end
            ACT_SLA:
            begin
                reg_out   = {v[6:0], 1'b0};
                flags_out = '{z: (v[6:0] == 7'd0), n: 1'b0, h: 1'b0, c: v[7]};
            end
            ACT_SRA:
            begin
                reg_out   = {v[7], v[7:1]};
                flags_out = '{z: (v[7:1] == 7'd0), n: 1'b0, h: 1'b0, c: v[0]};
            end
            ACT_SRL:
            begin
                reg_out   = {1'b0, v[7:1]};
                flags_out = '{z: (v[7:1] == 7'd0), n: 1'b0, h: 1'b0, c: v[0]};
            end
            ACT_BIT:
                flags_out = '{z: ((v & bit_mask) == 8'd0), n: 1'b0, h: 1'b1, c: cin};
            ACT_SET:
                reg_out = v | bit_mask;
            ACT_RES:
                reg_out = v & ~bit_mask;
            default:
            begin
                reg_out   = 8'd0;
                acc_out   = a;
                flags_out = flags;
            end
        endcase
    end

endmodule

// ===== rtl/cpu_alu_with_flags_unit.sv =====
`timescale 1ns / 1ps

// Accumulator ALU with Z, N, H and C flags. One request is taken each cycle
// while request ready is high: the request is captured in an
// input register, and one pass through the ALU writes the response register
// together with the accumulator and flags, so the next request already sees
// the updated state. Sustained rate is one request per cycle while responses
// are taken; when the response side stalls, the input register holds one more
// request before request ready drops. Reset clears the accumulator and flags.
module cpu_alu_with_flags_unit
    import cawf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp_data
);

    logic       in_valid_reg;
    req_t       in_req_reg;
    logic       rsp_valid_reg;
    rsp_t       rsp_reg;
    logic [7:0] acc_reg;
    flags_t     flags_reg;

    logic       advance;
    logic [7:0] reg_next;
    logic [7:0] acc_next;
    flags_t     flags_next;

    // The input register moves on when the response register is free.
    assign advance   = in_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !in_valid_reg || advance;

    cawf_alu u_alu (
        .req       (in_req_reg),
        .acc       (acc_reg),
        .flags     (flags_reg),
        .reg_out   (reg_next),
        .acc_out   (acc_next),
        .flags_out (flags_next)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req_ready)
            in_valid_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
            in_req_reg <= req_data;
    end

    // Architectural state and response valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 8'd0;
            flags_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                acc_reg   <= acc_next;
                flags_reg <= flags_next;
            end
            if (advance)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Response payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg.register_result <= reg_next;
            rsp_reg.accumulator_out <= acc_next;
            rsp_reg.flag_zero       <= flags_next.z;
            rsp_reg.flag_subtract   <= flags_next.n;
            rsp_reg.flag_half       <= flags_next.h;
            rsp_reg.flag_carry      <= flags_next.c;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule
